// ----- rtl/nalflv_pkg.sv -----
// Shared types and constants for the H.264 NAL to FLV video tag packer.
// No dependencies; nalflv_ctrl, nalflv_out and the top level import this package.
package nalflv_pkg;

    // Parameter defaults.
    localparam int SPS_CAPACITY_DEF = 48;
    localparam int LENGTH_BITS_DEF  = 24;

    // Field widths of the stream items.
    localparam int BYTE_W   = 8;
    localparam int TYPE_W   = 5;
    localparam int LEN_IN_W = 24;
    localparam int BLEN_W   = 25;

    // NAL unit types that get special handling.
    localparam logic [TYPE_W-1:0] NAL_IDR = 5'd5;
    localparam logic [TYPE_W-1:0] NAL_SPS = 5'd7;
    localparam logic [TYPE_W-1:0] NAL_PPS = 5'd8;

    // Start code handling.
    localparam int SC_CHECK_POS = 2;
    localparam int SC_SHORT     = 3;
    localparam int SC_LONG      = 4;

    // Fixed bytes of the FLV video tag bodies.
    localparam logic [BYTE_W-1:0] TAG_KEY       = 8'h17;
    localparam logic [BYTE_W-1:0] TAG_INTER     = 8'h27;
    localparam logic [BYTE_W-1:0] AVC_NALU      = 8'h01;
    localparam logic [BYTE_W-1:0] CFG_VERSION   = 8'h01;
    localparam logic [BYTE_W-1:0] CFG_LEN_SIZE  = 8'hFF;
    localparam logic [BYTE_W-1:0] CFG_NUM_SPS   = 8'hE1;
    localparam logic [BYTE_W-1:0] CFG_NUM_PPS   = 8'h01;

    // Header lengths and offsets.
    localparam int TAG_HDR_LEN    = 9;
    localparam int SEQ_SPS_OFS    = 13;
    localparam int SEQ_FIXED_LEN  = 16;
    localparam int SEQ_PROFILE_OFS = 5;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEQ_HDR,
        ST_TAG_HDR
    } t_state;

    // One result element on its way from the sequencer to the output register.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              use_ram;
        logic              ram_ok;
        logic              kind;
        logic              first;
        logic              last;
        logic [BLEN_W-1:0] blen;
        logic              bend;
    } t_elem;

endpackage

// ----- rtl/nalflv_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nalflv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while the read is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nalflv_ctrl.sv -----
// Input side and header sequencer: NAL state, SPS store writes, header bursts.
// Depends on nalflv_pkg; drives the SPS store RAM and the output stage.
module nalflv_ctrl #(
    parameter int SPS_CAPACITY = 48,
    parameter int LENGTH_BITS  = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [nalflv_pkg::BYTE_W-1:0]   i_byte,
    input  logic [nalflv_pkg::TYPE_W-1:0]   i_type,
    input  logic [nalflv_pkg::LEN_IN_W-1:0] i_length,
    input  logic                            i_first,
    input  logic                            i_take,
    output nalflv_pkg::t_elem               o_elem,
    output logic                            o_elem_valid,
    output logic                            o_ram_we,
    output logic [$clog2(SPS_CAPACITY)-1:0] o_ram_waddr,
    output logic [nalflv_pkg::BYTE_W-1:0]   o_ram_wdata,
    output logic [$clog2(SPS_CAPACITY)-1:0] o_ram_raddr
);

    import nalflv_pkg::*;

    localparam int ADDR_W = $clog2(SPS_CAPACITY);
    localparam int POS_W  = LENGTH_BITS;
    localparam int LEN_W  = (LENGTH_BITS < LEN_IN_W) ? LENGTH_BITS : LEN_IN_W;
    localparam int SLEN_W = $clog2(SPS_CAPACITY + 1);
    localparam int IDX_W  = $clog2(SPS_CAPACITY + SEQ_FIXED_LEN);
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    t_state               r_state, n_state;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [TYPE_W-1:0]    r_type, n_type;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_scf, n_scf;
    logic [SLEN_W-1:0]    r_sps_len, n_sps_len;
    logic [SPS_CAPACITY-1:0] r_ent_ok, n_ent_ok;
    logic [LEN_W-1:0]     r_pay, n_pay;
    logic [IDX_W-1:0]     r_idx, n_idx;

    logic                 c_fire;
    logic [TYPE_W-1:0]    c_type;
    logic [LEN_W-1:0]     c_len;
    logic [POS_W-1:0]     c_pos;
    logic [POS_W-1:0]     c_pos_inc;
    logic                 c_scf;
    logic [SLEN_W-1:0]    c_slen;
    logic                 c_live;
    logic                 c_is_last;
    logic                 c_code4;
    logic [LEN_W-1:0]     c_code_len;
    logic [LEN_W-1:0]     c_pay_pps;
    logic [LEN_W-1:0]     c_pay_tag;
    logic                 c_start_seq;
    logic                 c_start_tag;
    logic [IDX_W-1:0]     c_seq_last;
    logic [IDX_W-1:0]     c_sps_end;
    logic [IDX_W-1:0]     c_tail;
    logic                 c_seq_done;
    logic                 c_tag_done;
    logic [31:0]          c_pay32;
    logic [15:0]          c_slen16;
    logic [BLEN_W-1:0]    c_seq_blen;
    logic [BLEN_W-1:0]    c_tag_blen;

    // Items enter only between header bursts and when the next stage has room.
    assign o_ready = (r_state == ST_IDLE) && i_take;
    assign c_fire  = i_valid && o_ready;

    // NAL state as seen by the current item: a first byte relatches it.
    assign c_type    = i_first ? i_type : r_type;
    assign c_len     = i_first ? i_length[LEN_W-1:0] : r_len;
    assign c_pos     = i_first ? '0 : r_pos;
    assign c_scf     = i_first ? ((i_type == NAL_SPS) || (i_type == NAL_PPS)) : r_scf;
    assign c_slen    = (i_first && (i_type == NAL_SPS)) ? '0 : r_sps_len;
    assign c_pos_inc = (c_pos != POS_MAX) ? c_pos + POS_W'(1) : c_pos;
    assign c_live    = c_pos < POS_W'(c_len);
    assign c_is_last = ((POS_W + 1)'(c_pos) + (POS_W + 1)'(1)) == (POS_W + 1)'(c_len);

    // Payload lengths, saturating at zero for short units.
    assign c_code4    = (i_byte == '0);
    assign c_code_len = c_code4 ? LEN_W'(SC_LONG) : LEN_W'(SC_SHORT);
    assign c_pay_pps  = (c_len >= LEN_W'(SC_LONG)) ? c_len - LEN_W'(SC_LONG) : '0;
    assign c_pay_tag  = (c_len >= c_code_len) ? c_len - c_code_len : '0;

    // Burst bookkeeping.
    assign c_sps_end  = IDX_W'(SEQ_SPS_OFS) + IDX_W'(r_sps_len);
    assign c_seq_last = IDX_W'(SEQ_FIXED_LEN - 1) + IDX_W'(r_sps_len);
    assign c_tail     = r_idx - c_sps_end;
    assign c_seq_done = (r_idx == c_seq_last);
    assign c_tag_done = (r_idx == IDX_W'(TAG_HDR_LEN - 1));
    assign c_pay32    = 32'(r_pay);
    assign c_slen16   = 16'(r_sps_len);
    assign c_seq_blen = BLEN_W'(SEQ_FIXED_LEN) + BLEN_W'(r_sps_len) + BLEN_W'(r_pay);
    assign c_tag_blen = BLEN_W'(TAG_HDR_LEN) + BLEN_W'(r_pay);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (c_start_seq) begin
                    n_state = ST_SEQ_HDR;
                end else if (c_start_tag) begin
                    n_state = ST_TAG_HDR;
                end
            end
            ST_SEQ_HDR: begin
                if (i_take && c_seq_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TAG_HDR: begin
                if (i_take && c_tag_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, SPS store access and element generation.
    always_comb begin
        n_pos        = r_pos;
        n_type       = r_type;
        n_len        = r_len;
        n_scf        = r_scf;
        n_sps_len    = r_sps_len;
        n_ent_ok     = r_ent_ok;
        n_pay        = r_pay;
        n_idx        = r_idx;
        c_start_seq  = 1'b0;
        c_start_tag  = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = c_slen[ADDR_W-1:0];
        o_ram_wdata  = i_byte;
        o_ram_raddr  = '0;
        o_elem       = '0;
        o_elem_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (c_fire) begin
                    n_type    = c_type;
                    n_len     = c_len;
                    n_pos     = c_pos_inc;
                    n_scf     = c_scf;
                    n_sps_len = c_slen;
                    if (c_live) begin
                        if (c_type == NAL_SPS) begin
                            // Store the SPS body past its start code, up to capacity.
                            if ((c_pos >= POS_W'(SC_LONG)) &&
                                (c_slen < SLEN_W'(SPS_CAPACITY))) begin
                                o_ram_we                      = 1'b1;
                                n_ent_ok[c_slen[ADDR_W-1:0]] = 1'b1;
                                n_sps_len                     = c_slen + SLEN_W'(1);
                            end
                        end else if (c_type == NAL_PPS) begin
                            if (c_pos == '0) begin
                                n_pay       = c_pay_pps;
                                n_idx       = '0;
                                c_start_seq = 1'b1;
                            end else if (c_pos >= POS_W'(SC_LONG)) begin
                                o_elem_valid = 1'b1;
                                o_elem.data  = i_byte;
                                o_elem.kind  = 1'b1;
                                o_elem.last  = c_is_last;
                                o_elem.bend  = 1'b1;
                            end
                        end else begin
                            if (c_pos == POS_W'(SC_CHECK_POS)) begin
                                // Start code length is known here.
                                n_scf       = c_code4;
                                n_pay       = c_pay_tag;
                                n_idx       = '0;
                                c_start_tag = 1'b1;
                            end else if ((c_pos > POS_W'(SC_CHECK_POS)) &&
                                         (c_pos >= POS_W'(c_scf ? SC_LONG : SC_SHORT))) begin
                                o_elem_valid = 1'b1;
                                o_elem.data  = i_byte;
                                o_elem.last  = c_is_last;
                                o_elem.bend  = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_SEQ_HDR: begin
                if (i_take) begin
                    o_elem_valid = 1'b1;
                    o_elem.kind  = 1'b1;
                    o_elem.first = (r_idx == '0);
                    o_elem.blen  = (r_idx == '0) ? c_seq_blen : '0;
                    o_elem.bend  = c_seq_done;
                    o_elem.last  = c_seq_done && (r_pay == '0);
                    n_idx        = r_idx + IDX_W'(1);
                    case (r_idx)
                        IDX_W'(0): o_elem.data = TAG_KEY;
                        IDX_W'(1), IDX_W'(2), IDX_W'(3), IDX_W'(4): o_elem.data = '0;
                        IDX_W'(5): o_elem.data = CFG_VERSION;
                        IDX_W'(6), IDX_W'(7), IDX_W'(8): begin
                            // Profile, compatibility and level bytes of the stored SPS.
                            o_ram_raddr    = ADDR_W'(r_idx - IDX_W'(SEQ_PROFILE_OFS));
                            o_elem.use_ram = 1'b1;
                        end
                        IDX_W'(9):  o_elem.data = CFG_LEN_SIZE;
                        IDX_W'(10): o_elem.data = CFG_NUM_SPS;
                        IDX_W'(11): o_elem.data = c_slen16[15:8];
                        IDX_W'(12): o_elem.data = c_slen16[7:0];
                        default: begin
                            if (r_idx < c_sps_end) begin
                                o_ram_raddr    = ADDR_W'(r_idx - IDX_W'(SEQ_SPS_OFS));
                                o_elem.use_ram = 1'b1;
                            end else begin
                                case (c_tail)
                                    IDX_W'(0): o_elem.data = CFG_NUM_PPS;
                                    IDX_W'(1): o_elem.data = c_pay32[15:8];
                                    default:   o_elem.data = c_pay32[7:0];
                                endcase
                            end
                        end
                    endcase
                    o_elem.ram_ok = o_elem.use_ram && r_ent_ok[o_ram_raddr];
                end
            end
            ST_TAG_HDR: begin
                if (i_take) begin
                    o_elem_valid = 1'b1;
                    o_elem.first = (r_idx == '0);
                    o_elem.blen  = (r_idx == '0) ? c_tag_blen : '0;
                    o_elem.bend  = c_tag_done;
                    o_elem.last  = c_tag_done && (r_pay == '0);
                    n_idx        = r_idx + IDX_W'(1);
                    case (r_idx)
                        IDX_W'(0): o_elem.data = (r_type == NAL_IDR) ? TAG_KEY : TAG_INTER;
                        IDX_W'(1): o_elem.data = AVC_NALU;
                        IDX_W'(5): o_elem.data = c_pay32[31:24];
                        IDX_W'(6): o_elem.data = c_pay32[23:16];
                        IDX_W'(7): o_elem.data = c_pay32[15:8];
                        IDX_W'(8): o_elem.data = c_pay32[7:0];
                        default:   o_elem.data = '0;
                    endcase
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_type    <= '0;
            r_len     <= '0;
            r_scf     <= 1'b0;
            r_sps_len <= '0;
            r_ent_ok  <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_len     <= n_len;
            r_scf     <= n_scf;
            r_sps_len <= n_sps_len;
            r_ent_ok  <= n_ent_ok;
            r_idx     <= n_idx;
        end
    end

    // Payload length of the packet in progress.
    always_ff @(posedge i_clk) begin
        r_pay <= n_pay;
    end

endmodule

// ----- rtl/nalflv_out.sv -----
// Output side: RAM data stage and output register with stream handshake.
// Depends on nalflv_pkg; takes elements from nalflv_ctrl and SPS store data.
module nalflv_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nalflv_pkg::t_elem             i_elem,
    input  logic                          i_elem_valid,
    input  logic [nalflv_pkg::BYTE_W-1:0] i_rdata,
    output logic                          o_take,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nalflv_pkg::BYTE_W-1:0] o_byte,
    output logic                          o_kind,
    output logic                          o_first,
    output logic                          o_last,
    output logic [nalflv_pkg::BLEN_W-1:0] o_blen,
    output logic                          o_bend
);

    import nalflv_pkg::*;

    logic              r_p_valid;
    t_elem             r_p;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_kind;
    logic              r_o_first;
    logic              r_o_last;
    logic [BLEN_W-1:0] r_o_blen;
    logic              r_o_bend;
    logic              c_adv;
    logic [BYTE_W-1:0] c_byte;

    // The output register moves when empty or when its transfer completes.
    assign c_adv  = !r_o_valid || i_ready;
    assign o_take = !r_p_valid || c_adv;

    // Entries never written since reset read as zero.
    assign c_byte = r_p.use_ram ? (r_p.ram_ok ? i_rdata : '0) : r_p.data;

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_p_valid <= i_elem_valid;
            end
            if (c_adv) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_p <= i_elem;
        end
        if (c_adv) begin
            r_o_byte  <= c_byte;
            r_o_kind  <= r_p.kind;
            r_o_first <= r_p.first;
            r_o_last  <= r_p.last;
            r_o_blen  <= r_p.blen;
            r_o_bend  <= r_p.bend;
        end
    end

    assign o_valid = r_o_valid;
    assign o_byte  = r_o_byte;
    assign o_kind  = r_o_kind;
    assign o_first = r_o_first;
    assign o_last  = r_o_last;
    assign o_blen  = r_o_blen;
    assign o_bend  = r_o_bend;

endmodule

// ----- rtl/h264_nal_to_flv_video_tag_packer.sv -----
// Payload bytes: one accepted per cycle while no header burst runs and output has room;
// each passes the RAM data stage and output register. Sequence header: 16 + SPS length
// bytes, started by the PPS start byte; tag header: 9 bytes, started by the third NAL
// byte. Header bursts hold the input; one byte issues per cycle while output has room.
// Reset is synchronous, active low; SPS store entries unwritten since reset read as zero.
module h264_nal_to_flv_video_tag_packer #(
    parameter int SPS_CAPACITY = nalflv_pkg::SPS_CAPACITY_DEF,
    parameter int LENGTH_BITS  = nalflv_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // nal_byte[7:0], nal_length[31:8]
    input  logic [5:0]  i_s_tuser,   // nal_type[4:0], nal_first[5]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // out_byte[7:0], body_length[32:8], zero[39:33]
    output logic [2:0]  o_m_tuser,   // packet_kind[0], packet_first[1], burst_end[2]
    output logic        o_m_tlast    // packet_last
);

    import nalflv_pkg::*;

    localparam int ADDR_W = $clog2(SPS_CAPACITY);

    t_elem             w_elem;
    logic              w_elem_valid;
    logic              w_take;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;
    logic [BYTE_W-1:0] w_byte;
    logic              w_kind;
    logic              w_first;
    logic [BLEN_W-1:0] w_blen;
    logic              w_bend;

    // Input handling and header sequencing.
    nalflv_ctrl #(
        .SPS_CAPACITY (SPS_CAPACITY),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_byte       (i_s_tdata[7:0]),
        .i_type       (i_s_tuser[4:0]),
        .i_length     (i_s_tdata[31:8]),
        .i_first      (i_s_tuser[5]),
        .i_take       (w_take),
        .o_elem       (w_elem),
        .o_elem_valid (w_elem_valid),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr)
    );

    // SPS store; the read is issued together with the element that needs it.
    nalflv_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SPS_CAPACITY)
    ) u_sps_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_take),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register stage.
    nalflv_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem       (w_elem),
        .i_elem_valid (w_elem_valid),
        .i_rdata      (w_ram_rdata),
        .o_take       (w_take),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (w_byte),
        .o_kind       (w_kind),
        .o_first      (w_first),
        .o_last       (o_m_tlast),
        .o_blen       (w_blen),
        .o_bend       (w_bend)
    );

    assign o_m_tdata = {7'd0, w_blen, w_byte};
    assign o_m_tuser = {w_bend, w_first, w_kind};

endmodule

// ----- rtl/nalflv_chk.sv -----
// Port-level checks for the NAL to FLV video tag packer.
// Depends only on the top level's ports; bound to the top level below.
module nalflv_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic [5:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled output transfer keeps its item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output item changed while stalled");

    // A packet body is never shorter than its tag header.
    a_first_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata[32:8] >= 25'd9)
        else $error("body length below header size");

    // The length field is zero away from the first byte of a packet.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[1] |-> o_m_tdata[32:8] == 25'd0)
        else $error("body length set on a non-first byte");

    // The end of a packet is always the end of the burst that made it.
    a_last_bend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[2])
        else $error("packet end without burst end");

    // While a header burst is still being produced no input is taken.
    a_burst_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser[1] && !o_m_tuser[2] |-> !o_s_tready)
        else $error("input taken during a header burst");

endmodule

bind h264_nal_to_flv_video_tag_packer nalflv_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
